>>> src/gtm_pkg.sv
// Shared types and constants for the gray threshold and morphology cleanup block.
// No dependencies.
package gtm_pkg;

  typedef enum logic [1:0] {
    GRAY_AVG  = 2'd0,
    GRAY_PEAK = 2'd1,
    GRAY_LUMA = 2'd2
  } gray_mode_e;

  typedef enum logic [2:0] {
    CFG_GRAY_MODE = 3'd0,
    CFG_BG_THR    = 3'd1,
    CFG_BIN_THR   = 3'd2,
    CFG_RADIUS    = 3'd3,
    CFG_WIDTH     = 3'd4,
    CFG_HEIGHT    = 3'd5
  } cfg_idx_e;

  localparam int unsigned CFG_DW = 11;

  localparam logic [6:0]  LUMA_R      = 7'd30;
  localparam logic [6:0]  LUMA_G      = 7'd59;
  localparam logic [6:0]  LUMA_B      = 7'd11;
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int unsigned RECIP100_SH = 19;
  localparam logic [9:0]  RECIP3      = 10'd683;
  localparam int unsigned RECIP3_SH   = 11;

  localparam int unsigned QDEPTH = 4;

  typedef struct packed {
    logic valid;
    logic wr;
    logic pix;
    logic last;
  } slot_t;

endpackage

>>> src/gray_threshold_morph_cleanup.sv
// Top level: configuration registers, front end, queue and two morphology passes.
// Depends on gtm_pkg, gtm_front, gtm_fifo, gtm_morph.
//
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i, in_stall_o | blue_i green_i red_i flush_i
//  out     | source    | out_valid_o,out_stall_i| pixel_white_o out_row_o out_col_o frame_end_o
//  cfg     | sink      | cfg_we_i               | cfg_idx_i cfg_data_i
//
// One item per cycle unless the queue is full or the output stalls; the front end
// classifies in the accepting cycle; each back-end pass has four registered stages.
// Results lag the input stream by 2*(r*width + r) items; flushes drain the tail.
// Reset is asynchronous; line stores need no clearing pass.
// An output stall freezes the back end; the four-entry queue absorbs the front end.
module gray_threshold_morph_cleanup
  import gtm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RADIUS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        blue_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        red_i,
  input  logic              flush_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              pixel_white_o,
  output logic [9:0]        out_row_o,
  output logic [9:0]        out_col_o,
  output logic              frame_end_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RB  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned DB  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int unsigned TB  = $clog2(MAX_WIDTH * MAX_HEIGHT +
                                       2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS) + 1);
  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned CYW = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 2);

  gray_mode_e     mode_q;
  logic [7:0]     bg_q, bin_q;
  logic [1:0]     rad_q;
  logic [10:0]    fw_q, fh_q;
  logic           clear;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [RB-1:0]  r_eff;
  logic [DB-1:0]  d1;
  logic [TB-1:0]  total, endt;

  logic           accept, push, empty, full, en;
  slot_t          frec, qrec, s1_in, s1_out, s2_out;
  logic [CYW-1:0] row1, row2;
  logic [CW-1:0]  col1, col2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= GRAY_AVG;
      bg_q   <= 8'd255;
      bin_q  <= 8'd127;
      rad_q  <= 2'd1;
      fw_q   <= 11'd640;
      fh_q   <= 11'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRAY_MODE: mode_q <= gray_mode_e'(cfg_data_i[1:0]);
        CFG_BG_THR:    bg_q   <= cfg_data_i[7:0];
        CFG_BIN_THR:   bin_q  <= cfg_data_i[7:0];
        CFG_RADIUS:    rad_q  <= cfg_data_i[1:0];
        CFG_WIDTH:     fw_q   <= cfg_data_i;
        CFG_HEIGHT:    fh_q   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  assign clear = cfg_we_i && ((cfg_idx_i == CFG_RADIUS) || (cfg_idx_i == CFG_WIDTH) ||
                              (cfg_idx_i == CFG_HEIGHT));

  always_comb begin
    w_eff = (fw_q == '0) ? WW'(1) :
            ((32'(fw_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(fw_q));
    h_eff = (fh_q == '0) ? HW'(1) :
            ((32'(fh_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(fh_q));
    r_eff = (32'(rad_q) > MAX_RADIUS) ? RB'(MAX_RADIUS) : RB'(rad_q);
    d1    = DB'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
    total = TB'(32'(w_eff) * 32'(h_eff));
    endt  = TB'(32'(total) + 2 * 32'(d1) - 1);
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;
  assign en         = !(s2_out.valid && out_stall_i);

  gtm_front #(
    .TB (TB)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .blue_i    (blue_i),
    .green_i   (green_i),
    .red_i     (red_i),
    .flush_i   (flush_i),
    .mode_i    (mode_q),
    .bg_thr_i  (bg_q),
    .bin_thr_i (bin_q),
    .total_i   (total),
    .end_i     (endt),
    .clear_i   (clear),
    .push_o    (push),
    .rec_o     (frec)
  );

  gtm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (frec),
    .pop_i   (en),
    .data_o  (qrec),
    .empty_o (empty),
    .full_o  (full)
  );

  always_comb begin
    s1_in = qrec;
    s1_in.valid = !empty;
  end

  gtm_morph #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .ALL_WHITE  (1'b0)
  ) u_dilate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .clear_i (clear),
    .in_i    (s1_in),
    .w_i     (w_eff),
    .h_i     (h_eff),
    .r_i     (r_eff),
    .d1_i    (d1),
    .out_o   (s1_out),
    .row_o   (row1),
    .col_o   (col1)
  );

  gtm_morph #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .ALL_WHITE  (1'b1)
  ) u_erode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .clear_i (clear),
    .in_i    (s1_out),
    .w_i     (w_eff),
    .h_i     (h_eff),
    .r_i     (r_eff),
    .d1_i    (d1),
    .out_o   (s2_out),
    .row_o   (row2),
    .col_o   (col2)
  );

  assign out_valid_o   = s2_out.valid;
  assign pixel_white_o = s2_out.pix;
  assign frame_end_o   = s2_out.last;
  assign out_row_o     = 10'(row2);
  assign out_col_o     = 10'(col2);

  logic unused_ok;
  assign unused_ok = ^{row1, col1};

endmodule

>>> src/gtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/gtm_front.sv
// Front end: gray conversion, thresholds and slot counting of pushed items.
// Depends on gtm_pkg.
module gtm_front
  import gtm_pkg::*;
#(
  parameter int unsigned TB = 21
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    blue_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    red_i,
  input  logic          flush_i,
  input  gray_mode_e    mode_i,
  input  logic [7:0]    bg_thr_i,
  input  logic [7:0]    bin_thr_i,
  input  logic [TB-1:0] total_i,
  input  logic [TB-1:0] end_i,
  input  logic          clear_i,
  output logic          push_o,
  output slot_t         rec_o
);

  logic [TB-1:0] t_q, t_d;
  logic [9:0]    sum3;
  logic [14:0]   wsum;
  logic [7:0]    avg, luma, mx, gv, gth;
  logic          in_frame;

  always_comb begin
    sum3 = 10'(blue_i) + 10'(green_i) + 10'(red_i);
    wsum = 15'(red_i) * 15'(LUMA_R) + 15'(green_i) * 15'(LUMA_G) + 15'(blue_i) * 15'(LUMA_B);
    avg  = 8'((20'(sum3) * 20'(RECIP3)) >> RECIP3_SH);
    luma = 8'((28'(wsum) * 28'(RECIP100)) >> RECIP100_SH);
    mx   = (blue_i > green_i) ? blue_i : green_i;
    if (red_i > mx) begin
      mx = red_i;
    end
    unique case (mode_i)
      GRAY_PEAK: gv = mx;
      GRAY_LUMA: gv = luma;
      default:   gv = avg;
    endcase
    gth = (gv > bg_thr_i) ? 8'hff : gv;
    in_frame = t_q < total_i;
    push_o = accept_i && !(in_frame && flush_i);
    rec_o.valid = 1'b1;
    rec_o.wr    = in_frame;
    rec_o.pix   = gth > bin_thr_i;
    rec_o.last  = t_q == end_i;
    t_d = t_q;
    if (clear_i) begin
      t_d = '0;
    end else if (push_o) begin
      t_d = rec_o.last ? '0 : t_q + TB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= '0;
    end else begin
      t_q <= t_d;
    end
  end

endmodule

>>> src/gtm_fifo.sv
// Short queue of slot records between front end and morphology back end.
// Depends on gtm_pkg.
module gtm_fifo
  import gtm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  slot_t data_i,
  input  logic  pop_i,
  output slot_t data_o,
  output logic  empty_o,
  output logic  full_o
);

  localparam int unsigned PW = $clog2(QDEPTH);

  slot_t               mem_q [QDEPTH];
  logic [PW-1:0]       wp_q, rp_q;
  logic [PW:0]         cnt_q;
  logic                do_pop;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (PW+1)'(QDEPTH);
  assign data_o  = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= rp_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(do_pop);
    end
  end

endmodule

>>> src/gtm_morph.sv
// One morphology pass: column line store, window shift register and reduction.
// Depends on gtm_pkg and gtm_ram.
module gtm_morph
  import gtm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RADIUS = 3,
  parameter bit          ALL_WHITE  = 1'b0,
  localparam int unsigned NW  = 2 * MAX_RADIUS + 1,
  localparam int unsigned YB  = $clog2(NW),
  localparam int unsigned CW  = $clog2(MAX_WIDTH),
  localparam int unsigned CYW = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 2),
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned RB  = $clog2(MAX_RADIUS + 1),
  localparam int unsigned DB  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           clear_i,
  input  slot_t          in_i,
  input  logic [WW-1:0]  w_i,
  input  logic [HW-1:0]  h_i,
  input  logic [RB-1:0]  r_i,
  input  logic [DB-1:0]  d1_i,
  output slot_t          out_o,
  output logic [CYW-1:0] row_o,
  output logic [CW-1:0]  col_o
);

  logic [CW-1:0]  ux_q, cx_q, cur_cx;
  logic [YB-1:0]  ym_q;
  logic [CYW-1:0] cy_q, cur_cy;
  logic [DB-1:0]  cnt_q;
  logic           cact_q, cur_cv, cur_int, take;

  logic           a_v_q, a_wr_q, a_pix_q, a_last_q, a_cv_q, a_int_q, a_cw_q;
  logic [CW-1:0]  a_col_q, a_cx_q;
  logic [YB-1:0]  a_ym_q;
  logic [CYW-1:0] a_cy_q;

  logic           b_v_q, b_wr_q, b_pix_q, b_last_q, b_cv_q, b_int_q, b_cw_q;
  logic [CW-1:0]  b_col_q, b_cx_q;
  logic [YB-1:0]  b_ym_q;
  logic [CYW-1:0] b_cy_q;

  logic           c_v_q, c_cv_q, c_int_q, c_cw_q, c_last_q;
  logic [CW-1:0]  c_cx_q;
  logic [CYW-1:0] c_cy_q;

  logic           fw_v_q;
  logic [CW-1:0]  fw_addr_q;
  logic [NW-1:0]  fw_data_q;

  logic [NW-1:0]  rdata, word, vec;
  logic [NW-1:0]  sh_q [NW];
  logic           any_w, all_w, ctr, res;

  assign take = en_i && in_i.valid;

  always_comb begin
    cur_cv  = cact_q || (cnt_q == d1_i);
    cur_cy  = cact_q ? cy_q : '0;
    cur_cx  = cact_q ? cx_q : '0;
    cur_int = (32'(cur_cy) >= 32'(r_i)) && (32'(cur_cy) + 32'(r_i) < 32'(h_i)) &&
              (32'(cur_cx) >= 32'(r_i)) && (32'(cur_cx) + 32'(r_i) < 32'(w_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ux_q   <= '0;
      ym_q   <= '0;
      cx_q   <= '0;
      cy_q   <= '0;
      cnt_q  <= '0;
      cact_q <= 1'b0;
    end else if (clear_i || (take && in_i.last)) begin
      ux_q   <= '0;
      ym_q   <= '0;
      cx_q   <= '0;
      cy_q   <= '0;
      cnt_q  <= '0;
      cact_q <= 1'b0;
    end else if (take) begin
      if (32'(ux_q) + 1 == 32'(w_i)) begin
        ux_q <= '0;
        ym_q <= (32'(ym_q) + 1 == NW) ? '0 : ym_q + YB'(1);
      end else begin
        ux_q <= ux_q + CW'(1);
      end
      if (!cur_cv) begin
        cnt_q <= cnt_q + DB'(1);
      end
      cact_q <= cur_cv;
      if (cur_cv) begin
        if (32'(cur_cx) + 1 == 32'(w_i)) begin
          cx_q <= '0;
          cy_q <= cur_cy + CYW'(1);
        end else begin
          cx_q <= cur_cx + CW'(1);
          cy_q <= cur_cy;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      fw_v_q <= 1'b0;
      out_o  <= '0;
    end else if (en_i) begin
      a_v_q         <= in_i.valid;
      b_v_q         <= a_v_q;
      c_v_q         <= b_v_q;
      fw_v_q        <= b_v_q && b_wr_q;
      out_o.valid   <= c_v_q && c_cv_q;
      out_o.wr      <= c_cw_q;
      out_o.pix     <= res;
      out_o.last    <= c_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_wr_q   <= in_i.wr;
      a_pix_q  <= in_i.pix;
      a_last_q <= in_i.last;
      a_col_q  <= ux_q;
      a_ym_q   <= ym_q;
      a_cv_q   <= cur_cv;
      a_int_q  <= cur_int;
      a_cw_q   <= 32'(cur_cy) < 32'(h_i);
      a_cy_q   <= cur_cy;
      a_cx_q   <= cur_cx;

      b_wr_q   <= a_wr_q;
      b_pix_q  <= a_pix_q;
      b_last_q <= a_last_q;
      b_col_q  <= a_col_q;
      b_ym_q   <= a_ym_q;
      b_cv_q   <= a_cv_q;
      b_int_q  <= a_int_q;
      b_cw_q   <= a_cw_q;
      b_cy_q   <= a_cy_q;
      b_cx_q   <= a_cx_q;

      fw_addr_q <= b_col_q;
      fw_data_q <= word;

      c_cv_q   <= b_cv_q;
      c_int_q  <= b_int_q;
      c_cw_q   <= b_cw_q;
      c_last_q <= b_last_q;
      c_cy_q   <= b_cy_q;
      c_cx_q   <= b_cx_q;

      row_o <= c_cy_q;
      col_o <= c_cx_q;

      if (b_v_q) begin
        sh_q[0] <= vec;
        for (int k = 1; k < NW; k++) begin
          sh_q[k] <= sh_q[k-1];
        end
      end
    end
  end

  gtm_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (en_i && b_v_q && b_wr_q),
    .waddr_i (b_col_q),
    .wdata_i (word),
    .re_i    (en_i),
    .raddr_i (a_col_q),
    .rdata_o (rdata)
  );

  always_comb begin
    word = (fw_v_q && (fw_addr_q == b_col_q)) ? fw_data_q : rdata;
    if (b_wr_q) begin
      word[b_ym_q] = b_pix_q;
    end
    for (int k = 0; k < NW; k++) begin
      vec[k] = word[YB'((32'(b_ym_q) >= k) ? (32'(b_ym_q) - k) : (32'(b_ym_q) + NW - k))];
    end
  end

  always_comb begin
    any_w = 1'b0;
    all_w = 1'b1;
    ctr   = 1'b0;
    for (int k = 0; k < NW; k++) begin
      for (int j = 0; j < NW; j++) begin
        if ((k <= 2 * int'(r_i)) && (j <= 2 * int'(r_i))) begin
          any_w = any_w | sh_q[k][j];
          all_w = all_w & sh_q[k][j];
        end
      end
      if (k == int'(r_i)) begin
        ctr = sh_q[k][k];
      end
    end
    res = c_int_q ? (ALL_WHITE ? all_w : any_w) : ctr;
  end

endmodule

>>> src/gtm_checker.sv
// Port-level checks on the output stream of the cleanup block, bound to the top.
// No dependencies.
module gtm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  blue_i,
  input logic [7:0]  green_i,
  input logic [7:0]  red_i,
  input logic        flush_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        pixel_white_o,
  input logic [9:0]  out_row_o,
  input logic [9:0]  out_col_o,
  input logic        frame_end_o,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_idx_i,
  input logic [10:0] cfg_data_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({pixel_white_o, out_row_o, out_col_o, frame_end_o}))
    else $error("stalled result changed");

  a_col_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !frame_end_o |=> !out_valid_o ||
      out_col_o == $past(out_col_o) + 10'd1 || out_col_o == 10'd0)
    else $error("output column out of sequence");

  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o ||
      out_row_o == $past(out_row_o) || out_row_o == $past(out_row_o) + 10'd1 ||
      out_row_o == 10'd0)
    else $error("output row out of sequence");

endmodule

bind gray_threshold_morph_cleanup gtm_checker u_chk (.*);
